>>> hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Holds the controller states, the status codes and the command and status
// groups that pass between the controller and the datapath. No dependencies.
package spq_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Field widths of one stored entry.
    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 16;
    localparam int ENTRY_W = TAG_W + PRIO_W;

    // Result channel layout.
    localparam int COUNT_W   = 5;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 3;
    localparam int S_TDATA_W = 32;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_FULL      = 2'd2
    } spq_status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_SCAN,
        ST_ENQ_CHECK,
        ST_DEQ_POP,
        ST_DEQ_LOAD,
        ST_FINISH
    } spq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        latch_req;   // capture the accepted request
        logic        rd_prev;     // read the entry just below the insert position
        logic        rd_one;      // read the entry behind the head
        logic        shift_wr;    // move the read entry up one place
        logic        ins_wr;      // write the new entry at the insert position
        logic        deq_pop;     // remove the head entry
        logic        head_load;   // take the read entry as the new head
        logic        res_load;    // load the result register
        spq_status_t res_status;  // status code for the result
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;      // no free slot
        logic empty;     // no stored entry
        logic pos_zero;  // insert position is at the head
        logic prev_ge;   // read entry has priority greater than or equal to the new one
    } spq_flags_t;

endpackage

>>> hdl/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
// Sequences enqueue scans, dequeues and result loads; depends on spq_pkg.
module spq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,    // [0] request kind
    output logic                m_tvalid,
    input  logic                m_tready,
    input  spq_pkg::spq_flags_t flags,
    output spq_pkg::spq_cmd_t   cmd
);

    spq_pkg::spq_state_t  state_reg, state_next;
    spq_pkg::spq_status_t status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // State, status and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spq_pkg::ST_IDLE;
            status_reg   <= spq_pkg::STAT_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.res_status  = status_reg;

        case (state_reg)
            spq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_req = 1'b1;
                    if (s_tuser == spq_pkg::REQ_ENQUEUE) begin
                        if (flags.full) begin
                            status_next = spq_pkg::STAT_FULL;
                            state_next  = spq_pkg::ST_FINISH;
                        end else begin
                            status_next = spq_pkg::STAT_OK;
                            state_next  = spq_pkg::ST_ENQ_SCAN;
                        end
                    end else begin
                        if (flags.empty) begin
                            status_next = spq_pkg::STAT_UNDERFLOW;
                            state_next  = spq_pkg::ST_FINISH;
                        end else begin
                            status_next = spq_pkg::STAT_OK;
                            state_next  = spq_pkg::ST_DEQ_POP;
                        end
                    end
                end
            end
            spq_pkg::ST_ENQ_SCAN: begin
                // At the head the entry goes in directly; otherwise look below.
                if (flags.pos_zero) begin
                    cmd.ins_wr = 1'b1;
                    state_next = spq_pkg::ST_FINISH;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = spq_pkg::ST_ENQ_CHECK;
                end
            end
            spq_pkg::ST_ENQ_CHECK: begin
                // Entries of equal or larger priority move up to make room.
                if (flags.prev_ge) begin
                    cmd.shift_wr = 1'b1;
                    state_next   = spq_pkg::ST_ENQ_SCAN;
                end else begin
                    cmd.ins_wr = 1'b1;
                    state_next = spq_pkg::ST_FINISH;
                end
            end
            spq_pkg::ST_DEQ_POP: begin
                cmd.deq_pop = 1'b1;
                cmd.rd_one  = 1'b1;
                state_next  = spq_pkg::ST_DEQ_LOAD;
            end
            spq_pkg::ST_DEQ_LOAD: begin
                cmd.head_load = 1'b1;
                state_next    = spq_pkg::ST_FINISH;
            end
            spq_pkg::ST_FINISH: begin
                // Wait until the result register is free.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.res_load = 1'b1;
                    state_next   = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // The result stays valid until the downstream side takes it.
    always_comb begin
        if (cmd.res_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hdl/spq_datapath.sv
// Datapath for the sorted priority queue: entry memory, ring pointers,
// head and tail copies and the result register. Depends on spq_pkg.
module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [spq_pkg::S_TDATA_W-1:0]         s_tdata,  // [15:0] entry_tag, [31:16] entry_priority
    input  logic                                  s_tuser,  // [0] req_type
    // [15:0] out_tag, [31:16] out_priority, [47:32] head_tag, [63:48] head_priority,
    // [79:64] tail_tag, [95:80] tail_priority, [100:96] count, [101] is_empty
    output logic [spq_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [spq_pkg::M_TUSER_W-1:0]         m_tuser,  // [1:0] status, [2] out_valid
    input  spq_pkg::spq_cmd_t                     cmd,
    output spq_pkg::spq_flags_t                   flags
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Entry memory, {priority, tag} per slot, kept as a sorted ring.
    logic [spq_pkg::ENTRY_W-1:0] mem [DEPTH];

    logic [AW-1:0]    head_ptr_reg, head_ptr_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    logic                         req_type_reg;
    logic [spq_pkg::TAG_W-1:0]    req_tag_reg;
    logic [spq_pkg::PRIO_W-1:0]   req_prio_reg;
    logic [spq_pkg::TAG_W-1:0]    head_tag_reg, tail_tag_reg, deq_tag_reg;
    logic [spq_pkg::PRIO_W-1:0]   head_prio_reg, tail_prio_reg, deq_prio_reg;
    logic [spq_pkg::ENTRY_W-1:0]  rd_data_reg;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [spq_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [AW-1:0]               pos_lo, pos_m1, rd_addr, wr_addr;
    logic                        rd_en, wr_en;
    logic [spq_pkg::ENTRY_W-1:0] wr_data;
    logic [spq_pkg::TAG_W-1:0]   rd_tag;
    logic [spq_pkg::PRIO_W-1:0]  rd_prio;
    logic                        pos_at_end;

    // Map a position counted from the head onto a physical slot.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign pos_lo     = pos_reg[AW-1:0];
    assign pos_m1     = pos_lo - AW'(1);
    assign rd_tag     = rd_data_reg[spq_pkg::TAG_W-1:0];
    assign rd_prio    = rd_data_reg[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W];
    assign pos_at_end = (pos_reg == occ_reg);

    // Memory port selection.
    assign rd_en   = cmd.rd_prev | cmd.rd_one;
    assign rd_addr = cmd.rd_prev ? phys(head_ptr_reg, pos_m1) : phys(head_ptr_reg, AW'(1));
    assign wr_en   = cmd.shift_wr | cmd.ins_wr;
    assign wr_addr = phys(head_ptr_reg, pos_lo);
    assign wr_data = cmd.shift_wr ? rd_data_reg : {req_prio_reg, req_tag_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Flags for the controller.
    assign flags.full     = (occ_reg == CNT_W'(DEPTH));
    assign flags.empty    = (occ_reg == '0);
    assign flags.pos_zero = (pos_reg == '0);
    assign flags.prev_ge  = (rd_prio >= req_prio_reg);

    // Ring pointer, fill count and insert position.
    always_comb begin
        head_ptr_next = head_ptr_reg;
        occ_next      = occ_reg;
        pos_next      = pos_reg;
        if (cmd.latch_req) begin
            pos_next = occ_reg;
        end
        if (cmd.shift_wr) begin
            pos_next = pos_reg - CNT_W'(1);
        end
        if (cmd.ins_wr) begin
            occ_next = occ_reg + CNT_W'(1);
        end
        if (cmd.deq_pop) begin
            occ_next      = occ_reg - CNT_W'(1);
            head_ptr_next = (head_ptr_reg == AW'(DEPTH - 1)) ? '0 : head_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr_reg <= '0;
            occ_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            head_ptr_reg <= head_ptr_next;
            occ_reg      <= occ_next;
            pos_reg      <= pos_next;
        end
    end

    // Request capture and copies of the head and tail entries.
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_type_reg <= s_tuser;
            req_tag_reg  <= s_tdata[spq_pkg::TAG_W-1:0];
            req_prio_reg <= s_tdata[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W];
        end
        if (cmd.ins_wr) begin
            if (pos_reg == '0) begin
                head_tag_reg  <= req_tag_reg;
                head_prio_reg <= req_prio_reg;
            end
            if (pos_at_end) begin
                tail_tag_reg  <= req_tag_reg;
                tail_prio_reg <= req_prio_reg;
            end
        end
        if (cmd.deq_pop) begin
            deq_tag_reg  <= head_tag_reg;
            deq_prio_reg <= head_prio_reg;
        end
        if (cmd.head_load) begin
            head_tag_reg  <= rd_tag;
            head_prio_reg <= rd_prio;
        end
    end

    // Result assembly; empty queue and non-dequeue results read as zero.
    always_comb begin
        logic                   out_valid;
        logic                   is_empty;
        logic [CNT_W+4:0]       occ_ext;
        out_valid = (req_type_reg == spq_pkg::REQ_DEQUEUE)
                    && (cmd.res_status == spq_pkg::STAT_OK);
        is_empty  = (occ_reg == '0);
        occ_ext   = {5'b0, occ_reg};
        m_tdata_next          = '0;
        if (out_valid) begin
            m_tdata_next[15:0]  = deq_tag_reg;
            m_tdata_next[31:16] = deq_prio_reg;
        end
        if (!is_empty) begin
            m_tdata_next[47:32] = head_tag_reg;
            m_tdata_next[63:48] = head_prio_reg;
            m_tdata_next[79:64] = tail_tag_reg;
            m_tdata_next[95:80] = tail_prio_reg;
        end
        m_tdata_next[100:96] = occ_ext[spq_pkg::COUNT_W-1:0];
        m_tdata_next[101]    = is_empty;
        m_tuser_next         = {out_valid, cmd.res_status};
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue: up to DEPTH entries of a 16-bit tag and a 16-bit
// priority, held in one memory as a ring sorted by priority with the lowest
// number at the head. An enqueue goes ahead of stored entries of equal
// priority; a dequeue returns the head. Each request gives one result with
// the status, the dequeued entry, the head and tail entries, the count and an
// empty flag. Requests are taken one at a time; the next one is accepted while
// a finished result still waits on the output. An enqueue walks down from the
// tail past the stored entries with a priority greater than or equal to the
// new one, moving one entry per read and write pair of the memory. A result
// that is still held on the output keeps the next request in its finishing
// state until it is taken. Slots need no clearing after reset.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] entry_tag, [31:16] entry_priority
    input  logic                            s_tuser,  // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] out_tag, [31:16] out_priority, [47:32] head_tag, [63:48] head_priority,
    // [79:64] tail_tag, [95:80] tail_priority, [100:96] count, [101] is_empty
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [spq_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] status, [2] out_valid
);

    spq_pkg::spq_cmd_t   cmd;
    spq_pkg::spq_flags_t flags;

    // Sequencer.
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    // Storage and result formatting.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .flags   (flags)
    );

endmodule

>>> tb/sv/spq_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority queue: watches both stream channels, keeps
// its own sorted copy of the queue and compares every result field by field.
// Depends on spq_pkg for the status codes, request kinds and channel widths.
module spq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [spq_pkg::M_TUSER_W-1:0] m_tuser,
    output int                            fail_count,
    output int                            reports_pending
);

    // One result as the block should report it.
    typedef struct {
        spq_pkg::spq_status_t        status;
        logic                        deq_valid;
        logic [spq_pkg::TAG_W-1:0]   deq_tag;
        logic [spq_pkg::PRIO_W-1:0]  deq_prio;
        logic [spq_pkg::TAG_W-1:0]   head_tag;
        logic [spq_pkg::PRIO_W-1:0]  head_prio;
        logic [spq_pkg::TAG_W-1:0]   tail_tag;
        logic [spq_pkg::PRIO_W-1:0]  tail_prio;
        logic [spq_pkg::COUNT_W-1:0] count;
        logic                        empty;
    } queue_report_t;

    // Sorted copy of the stored entries, slot 0 is the head.
    logic [spq_pkg::TAG_W-1:0]  sorted_tag  [DEPTH];
    logic [spq_pkg::PRIO_W-1:0] sorted_prio [DEPTH];
    int                         sorted_fill;

    // Reports owed by the block, oldest first.
    queue_report_t reports_due[$];

    initial begin
        fail_count      = 0;
        reports_pending = 0;
        sorted_fill     = 0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
        fail_count++;
    endtask

    // Apply one request to the sorted copy and build the report it causes.
    function automatic queue_report_t serve_request(input logic kind,
                                                    input logic [spq_pkg::TAG_W-1:0] tag,
                                                    input logic [spq_pkg::PRIO_W-1:0] prio);
        queue_report_t r;
        int pos;
        r.status    = spq_pkg::STAT_OK;
        r.deq_valid = 1'b0;
        r.deq_tag   = '0;
        r.deq_prio  = '0;
        r.head_tag  = '0;
        r.head_prio = '0;
        r.tail_tag  = '0;
        r.tail_prio = '0;
        if (kind == spq_pkg::REQ_ENQUEUE) begin
            if (sorted_fill >= DEPTH) begin
                r.status = spq_pkg::STAT_FULL;
            end else begin
                // The new entry goes behind strictly smaller priorities only,
                // so it lands ahead of any equal ones.
                pos = 0;
                while (pos < sorted_fill && sorted_prio[pos] < prio) pos++;
                for (int i = sorted_fill; i > pos; i--) begin
                    sorted_tag[i]  = sorted_tag[i-1];
                    sorted_prio[i] = sorted_prio[i-1];
                end
                sorted_tag[pos]  = tag;
                sorted_prio[pos] = prio;
                sorted_fill++;
            end
        end else if (sorted_fill == 0) begin
            r.status = spq_pkg::STAT_UNDERFLOW;
        end else begin
            r.deq_valid = 1'b1;
            r.deq_tag   = sorted_tag[0];
            r.deq_prio  = sorted_prio[0];
            for (int i = 1; i < sorted_fill; i++) begin
                sorted_tag[i-1]  = sorted_tag[i];
                sorted_prio[i-1] = sorted_prio[i];
            end
            sorted_fill--;
        end
        // Head and tail read as zero while the queue is empty.
        if (sorted_fill > 0) begin
            r.head_tag  = sorted_tag[0];
            r.head_prio = sorted_prio[0];
            r.tail_tag  = sorted_tag[sorted_fill-1];
            r.tail_prio = sorted_prio[sorted_fill-1];
        end
        r.count = spq_pkg::COUNT_W'(sorted_fill);
        r.empty = (sorted_fill == 0);
        return r;
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        queue_report_t want;
        if (!aresetn) begin
            sorted_fill = 0;
            reports_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                reports_due.push_back(serve_request(s_tuser, s_tdata[15:0],
                                                    s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end else begin
                    want = reports_due.pop_front();
                    if (m_tuser[1:0] !== want.status)
                        report_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
                    if (m_tuser[2] !== want.deq_valid)
                        report_mismatch("out_valid", 32'(m_tuser[2]), 32'(want.deq_valid));
                    if (m_tdata[15:0] !== want.deq_tag)
                        report_mismatch("out_tag", 32'(m_tdata[15:0]), 32'(want.deq_tag));
                    if (m_tdata[31:16] !== want.deq_prio)
                        report_mismatch("out_priority", 32'(m_tdata[31:16]),
                                        32'(want.deq_prio));
                    if (m_tdata[47:32] !== want.head_tag)
                        report_mismatch("head_tag", 32'(m_tdata[47:32]), 32'(want.head_tag));
                    if (m_tdata[63:48] !== want.head_prio)
                        report_mismatch("head_priority", 32'(m_tdata[63:48]),
                                        32'(want.head_prio));
                    if (m_tdata[79:64] !== want.tail_tag)
                        report_mismatch("tail_tag", 32'(m_tdata[79:64]), 32'(want.tail_tag));
                    if (m_tdata[95:80] !== want.tail_prio)
                        report_mismatch("tail_priority", 32'(m_tdata[95:80]),
                                        32'(want.tail_prio));
                    if (m_tdata[100:96] !== want.count)
                        report_mismatch("count", 32'(m_tdata[100:96]), 32'(want.count));
                    if (m_tdata[101] !== want.empty)
                        report_mismatch("is_empty", 32'(m_tdata[101]), 32'(want.empty));
                    if (m_tdata[103:102] !== 2'b00)
                        report_mismatch("tdata padding", 32'(m_tdata[103:102]), 32'd0);
                end
            end
        end
        reports_pending = reports_due.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the sorted priority queue testbench: clock, reset, request stimulus
// and the result-side stall pattern. Depends on spq_pkg, spq_checker and the block.
module tb;

    localparam int QUEUE_DEPTH = 16;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = spq_pkg::REQ_ENQUEUE;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [spq_pkg::M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int reports_pending;

    // Sender burst state and a rough fill level used to steer the stimulus.
    int burst_left   = 0;
    int stored_guess = 0;

    // Receiver stall state.
    int stall_tick = 0;
    int stall_mode = 0;

    sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    spq_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    // 2 ns clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("FAIL sorted_priority_queue");
        $finish;
    end

    // The receiver switches at random among stall patterns: always ready,
    // coin flip, mostly stalled, and a fixed on-off rhythm from its tick counter.
    always @(negedge aclk) begin
        stall_tick++;
        if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= stall_tick[2];
        endcase
    end

    // Offer one request and hold it until accepted. Requests come in bursts
    // with random gaps in between.
    task automatic send_request(input logic kind, input logic [15:0] tag,
                                input logic [15:0] prio);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, tag};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (kind == spq_pkg::REQ_ENQUEUE && stored_guess < QUEUE_DEPTH) stored_guess++;
        if (kind == spq_pkg::REQ_DEQUEUE && stored_guess > 0) stored_guess--;
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reports_pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic        kind;
        logic [15:0] prio;
        bit          filling;
        int          prio_mode;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: underflow, extremes, ties, a full queue and a reject.
        send_request(spq_pkg::REQ_DEQUEUE, 16'h0000, 16'h0000);
        send_request(spq_pkg::REQ_ENQUEUE, 16'hFFFF, 16'hFFFF);
        send_request(spq_pkg::REQ_ENQUEUE, 16'h0000, 16'h0000);
        // Equal to the head priority, so it becomes the new head.
        send_request(spq_pkg::REQ_ENQUEUE, 16'h1234, 16'h0000);
        // Equal to the tail priority, so the old tail stays last.
        send_request(spq_pkg::REQ_ENQUEUE, 16'h5555, 16'hFFFF);
        send_request(spq_pkg::REQ_ENQUEUE, 16'hAAAA, 16'h8000);
        for (int i = 0; i < 11; i++) send_request(spq_pkg::REQ_ENQUEUE, 16'(i), 16'h8000);
        send_request(spq_pkg::REQ_ENQUEUE, 16'hBEEF, 16'h0001);
        repeat (3) send_request(spq_pkg::REQ_DEQUEUE, 16'hFFFF, 16'hFFFF);
        drain_results();

        // Random part: sweeps between filling and draining so the queue
        // spends time at every depth, full and empty included.
        filling = 1'b1;
        for (int n = 0; n < 1500; n++) begin
            if (filling && stored_guess >= QUEUE_DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && stored_guess == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;

            if ($urandom_range(0, 99) < 75)
                kind = filling ? spq_pkg::REQ_ENQUEUE : spq_pkg::REQ_DEQUEUE;
            else
                kind = filling ? spq_pkg::REQ_DEQUEUE : spq_pkg::REQ_ENQUEUE;

            // Mix wide priorities with narrow ranges that force ties.
            prio_mode = $urandom_range(0, 3);
            case (prio_mode)
                0, 1: prio = 16'($urandom_range(0, 65535));
                2: prio = 16'($urandom_range(0, 7));
                default: prio = $urandom_range(0, 1) ? 16'(65535 - $urandom_range(0, 2))
                                                     : 16'($urandom_range(0, 2));
            endcase
            send_request(kind, 16'($urandom_range(0, 65535)), prio);

            if (n == 700 || $urandom_range(0, 249) == 0) drain_results();
        end

        drain_results();
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && reports_pending == 0) begin
            $display("PASS sorted_priority_queue");
        end else begin
            $display("FAIL sorted_priority_queue");
        end
        $finish;
    end

endmodule
